@@ hdl/ffba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the FIFO free block allocator: field widths,
// stream widths, request kinds and result status codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

	// Field widths
	localparam int IDX_W    = 7;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;

	// Stream widths (tdata padded to whole bytes)
	localparam int S_DATA_W = 8;
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = 16;
	localparam int M_USER_W = STATUS_W;

	// Request kind carried in s_axis_tuser
	typedef enum logic [S_USER_W-1:0] {
		MODE_ALLOC   = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

	// Result status carried in m_axis_tuser
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_DUP   = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

@@ hdl/fifo_free_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_free_block_allocator
// First-in first-out pool of free block numbers with a per-block free bitmap.
// ----------------------------------------------------------------------------
// Each request (allocate or release) yields one result carrying the granted
// block, a status code and the free count after the request. One request is
// taken per clock while the output is not stalled: a request sits in the
// input stage, where the free bitmap read issued at its transfer and the
// prefetched head slot of the ring are resolved, and its result is then
// loaded into the output register. After reset the block runs an
// initialization sweep over all BLOCKS slots that loads slot i of the ring with
// block i and marks every block free; s_axis_tready stays low for the sweep.
// Release of an index at or beyond BLOCKS, or of a block already free, leaves
// the pool unchanged and is flagged in the status.
// ----------------------------------------------------------------------------
module fifo_free_block_allocator #(
	parameter int BLOCKS = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [6:0] release_index, [7] zero
	input  logic [ffba_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// [0] mode
	input  logic [ffba_pkg::S_USER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [6:0] granted_index, [14:7] free_count, [15] zero
	output logic [ffba_pkg::M_DATA_W-1:0]     m_axis_tdata,
	// [1:0] status
	output logic [ffba_pkg::M_USER_W-1:0]     m_axis_tuser
);

	import ffba_pkg::*;

	localparam int SLOT_W = $clog2(BLOCKS);
	localparam int CNT_W  = $clog2(BLOCKS + 1);

	// Init sweep
	logic              init_q;
	logic [SLOT_W-1:0] init_cnt_q;

	// Input stage
	logic              valid_s1;
	mode_t             mode_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              mark_s1;

	// Pool state
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;

	// Output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  granted_q;
	status_t           status_q;
	logic [COUNT_W-1:0] free_count_q;

	// Decision logic
	logic              in_xfer;
	logic              fire;
	logic              is_rel;
	logic              in_range;
	logic              alloc_ok;
	logic              rel_ok;
	logic [SLOT_W-1:0] idx_slot;
	logic [SLOT_W-1:0] head_blk;
	logic [SLOT_W-1:0] head_inc;
	logic [SLOT_W:0]   tail_sum;
	logic [SLOT_W-1:0] tail;
	logic [CNT_W-1:0]  count_next;
	status_t           status_d;
	logic [IDX_W-1:0]  granted_d;

	// Ring and bitmap ports
	logic              ring_we;
	logic [SLOT_W-1:0] ring_waddr;
	logic [SLOT_W-1:0] ring_wdata;
	logic [SLOT_W-1:0] ring_raddr;
	logic              mk_mem [BLOCKS];
	logic              mk_we;
	logic [SLOT_W-1:0] mk_waddr;
	logic              mk_wdata;
	logic [SLOT_W-1:0] mk_raddr;

	// Handshakes
	assign fire          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !init_q && (!valid_s1 || fire);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Init sweep over all slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b1;
			init_cnt_q <= '0;
		end else if (init_q) begin
			init_cnt_q <= init_cnt_q + 1'b1;
			if (init_cnt_q == SLOT_W'(BLOCKS - 1)) begin
				init_q <= 1'b0;
			end
		end
	end

	// Request decode
	assign is_rel   = (mode_s1 == MODE_RELEASE);
	assign in_range = (32'(idx_s1) < 32'(BLOCKS));
	assign idx_slot = SLOT_W'(idx_s1);
	assign alloc_ok = !is_rel && (count_q != '0);
	assign rel_ok   = is_rel && in_range && !mark_s1 && (count_q < CNT_W'(BLOCKS));

	// Ring pointer arithmetic
	assign head_inc = (head_q == SLOT_W'(BLOCKS - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum = (SLOT_W+1)'(head_q) + (SLOT_W+1)'(count_q);
	assign tail     = (tail_sum >= (SLOT_W+1)'(BLOCKS)) ?
	                  SLOT_W'(tail_sum - (SLOT_W+1)'(BLOCKS)) : SLOT_W'(tail_sum);

	// Result and next count
	always_comb begin
		count_next = count_q;
		granted_d  = '0;
		status_d   = ST_OK;
		if (!is_rel) begin
			if (alloc_ok) begin
				count_next = count_q - 1'b1;
				granted_d  = IDX_W'(head_blk);
			end else begin
				status_d = ST_EMPTY;
			end
		end else if (!in_range) begin
			status_d = ST_RANGE;
		end else if (!rel_ok) begin
			status_d = ST_DUP;
		end else begin
			count_next = count_q + 1'b1;
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1 <= mode_t'(s_axis_tuser);
			idx_s1  <= s_axis_tdata[IDX_W-1:0];
		end
	end

	// Pool state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= CNT_W'(BLOCKS);
		end else if (fire) begin
			if (alloc_ok) begin
				head_q <= head_inc;
			end
			count_q <= count_next;
		end
	end

	// Ring storage with prefetched head slot
	assign ring_we    = init_q || (fire && rel_ok);
	assign ring_waddr = init_q ? init_cnt_q : tail;
	assign ring_wdata = init_q ? init_cnt_q : idx_slot;
	assign ring_raddr = (fire && alloc_ok) ? head_inc : head_q;

	ffba_ring #(
		.BLOCKS (BLOCKS)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ring_we),
		.waddr  (ring_waddr),
		.wdata  (ring_wdata),
		.raddr  (ring_raddr),
		.rdata  (head_blk)
	);

	// Free bitmap: read at transfer, written by the init sweep and when a request succeeds
	assign mk_we    = init_q || (fire && (alloc_ok || rel_ok));
	assign mk_waddr = init_q ? init_cnt_q : (alloc_ok ? head_blk : idx_slot);
	assign mk_wdata = init_q || rel_ok;
	assign mk_raddr = SLOT_W'(s_axis_tdata[IDX_W-1:0]);

	always_ff @(posedge clk) begin
		if (mk_we) begin
			mk_mem[mk_waddr] <= mk_wdata;
		end
		if (in_xfer) begin
			mark_s1 <= (mk_we && (mk_waddr == mk_raddr)) ? mk_wdata : mk_mem[mk_raddr];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			granted_q    <= granted_d;
			status_q     <= status_d;
			free_count_q <= COUNT_W'(count_next);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, free_count_q, granted_q};
	assign m_axis_tuser  = status_q;

`ifndef SYNTHESIS
	// Free count never exceeds the pool size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BLOCKS))
		else $error("free count above pool size");

	// An empty-pool result reports zero free blocks
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_EMPTY) |-> free_count_q == '0)
		else $error("empty status with nonzero free count");

	// Only a successful request may carry a granted block
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_OK) |-> granted_q == '0)
		else $error("granted block on a failed request");

	// A granted block drops the count by one
	a_alloc_dec: assert property (@(posedge clk) disable iff (!arst_n)
		fire && alloc_ok |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("free count not decremented on allocate");

	// No request enters while the init sweep runs
	a_init_idle: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !valid_s1)
		else $error("request in flight during init sweep");
`endif

endmodule

@@ hdl/ffba_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ring
// Free list ring storage. One write port, one read port with registered
// read data; a write to the address being read is forwarded so the head
// word always shows the current contents of the addressed slot.
// ----------------------------------------------------------------------------
module ffba_ring #(
	parameter int BLOCKS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [$clog2(BLOCKS)-1:0]   waddr,
	input  logic [$clog2(BLOCKS)-1:0]   wdata,
	input  logic [$clog2(BLOCKS)-1:0]   raddr,
	output logic [$clog2(BLOCKS)-1:0]   rdata
);

	localparam int SLOT_W = $clog2(BLOCKS);

	logic [SLOT_W-1:0] ring_mem [BLOCKS];
	logic [SLOT_W-1:0] rd_q;
	logic [SLOT_W-1:0] byp_data_q;
	logic              byp_q;

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			ring_mem[waddr] <= wdata;
		end
		rd_q       <= ring_mem[raddr];
		byp_data_q <= wdata;
	end

	// Read-during-write forwarding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (waddr == raddr);
		end
	end

	assign rdata = byp_q ? byp_data_q : rd_q;

endmodule
